// ----- design/wsd_pkg.sv -----
// Shared types and constants for the stereo waveshaper distortion block.
// Depends on nothing; the channel datapath and the top level use it.
`timescale 1ns / 1ps
`default_nettype none
package wsd_pkg;
    localparam int IFRAC     = 20;
    localparam int DIV_BITS  = 22;
    localparam int M_BITS    = 28;
    localparam int SQ_BITS   = 35;
    localparam int CUBE_BITS = 43;
    localparam int NUM_BITS  = 36;
    localparam int REM_BITS  = 64;
    localparam int LATENCY   = DIV_BITS + 7;

    localparam logic [M_BITS-1:0]    Y_LIM  = M_BITS'(128) << IFRAC;
    localparam logic [M_BITS-1:0]    HALF_Q = M_BITS'(1) << (IFRAC - 1);
    localparam logic [CUBE_BITS-1:0] ONE_Q  = CUBE_BITS'(1) << IFRAC;
    localparam logic [CUBE_BITS-1:0] K07    = CUBE_BITS'(734003);
    localparam logic [CUBE_BITS-1:0] K06    = CUBE_BITS'(629146);
    localparam logic [18:0]          K03    = 19'd314573;

    localparam logic ADDR_MODE = 1'b0;
    localparam logic ADDR_GAIN = 1'b1;

    typedef enum logic [2:0] {
        MODE_NONE    = 3'd0,
        MODE_SOFT    = 3'd1,
        MODE_HARD    = 3'd2,
        MODE_HF0     = 3'd3,
        MODE_HF1     = 3'd4,
        MODE_HF2     = 3'd5,
        MODE_DIGITAL = 3'd6
    } t_mode;
endpackage
`default_nettype wire

// ----- design/wsd_channel.sv -----
// Pipelined datapath for one channel: drive, curve, restoring divider, scale.
// Depends on wsd_pkg; instantiated twice by the top level.
`timescale 1ns / 1ps
`default_nettype none
module wsd_channel #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 20
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [2:0]             i_mode,
    input  wire logic [15:0]            i_gain,
    output logic      [SAMPLE_BITS-1:0] o_out,
    output logic                        o_clip
);
    localparam int SB        = SAMPLE_BITS;
    localparam int DRV_SHIFT = FRAC_BITS + 9 - wsd_pkg::IFRAC;
    localparam int OUT_SHIFT = 2 * wsd_pkg::IFRAC - FRAC_BITS;
    localparam int PW        = wsd_pkg::DIV_BITS + 19;
    localparam int DB        = wsd_pkg::DIV_BITS;

    wsd_pkg::t_mode mode;
    logic           byp;
    assign mode = wsd_pkg::t_mode'(i_mode);
    assign byp  = (mode == wsd_pkg::MODE_NONE) || (i_mode == 3'd7);

    // Stage 1: magnitude and products.
    logic [SB-1:0]    n_mag;
    logic             r1_neg;
    logic [SB+15:0]   r1_prod;
    logic [SB+18:0]   r1_mk;
    assign n_mag = i_sample[SB-1] ? (~i_sample + SB'(1)) : i_sample;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_neg  <= i_sample[SB-1];
            r1_prod <= n_mag * i_gain;
            r1_mk   <= n_mag * wsd_pkg::K03;
        end
    end

    // Stage 2: drive shift and clamp.
    logic [SB+15:0]               n_mfull;
    logic [wsd_pkg::M_BITS-1:0]   r2_m;
    logic                         r2_clip, r2_neg;
    logic [SB-1:0]                r2_byp;
    logic [SB+18:0]               n_bq;
    assign n_mfull = r1_prod >> DRV_SHIFT;
    assign n_bq    = r1_mk >> wsd_pkg::IFRAC;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_neg <= r1_neg;
            r2_byp <= n_bq[SB-1:0];
            if (!byp && (n_mfull > (SB+16)'(wsd_pkg::Y_LIM))) begin
                r2_m    <= wsd_pkg::Y_LIM;
                r2_clip <= 1'b1;
            end else begin
                r2_m    <= n_mfull[wsd_pkg::M_BITS-1:0];
                r2_clip <= 1'b0;
            end
        end
    end

    // Stage 3: square.
    logic [2*wsd_pkg::M_BITS-1:0] n_sqp;
    logic [wsd_pkg::SQ_BITS-1:0]  r3_sq;
    logic [wsd_pkg::M_BITS-1:0]   r3_m;
    logic                         r3_clip, r3_neg;
    logic [SB-1:0]                r3_byp;
    assign n_sqp = r2_m * r2_m;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_sq   <= n_sqp[wsd_pkg::IFRAC +: wsd_pkg::SQ_BITS];
            r3_m    <= r2_m;
            r3_clip <= r2_clip;
            r3_neg  <= r2_neg;
            r3_byp  <= r2_byp;
        end
    end

    // Stage 4: cube, numerator and result sign.
    logic [wsd_pkg::SQ_BITS+wsd_pkg::M_BITS-1:0] n_cp;
    logic [wsd_pkg::NUM_BITS-1:0]  n_num;
    logic                          n_zneg;
    logic [wsd_pkg::CUBE_BITS-1:0] r4_cube;
    logic [wsd_pkg::SQ_BITS-1:0]   r4_sq;
    logic [wsd_pkg::M_BITS-1:0]    r4_m;
    logic [wsd_pkg::NUM_BITS-1:0]  r4_num;
    logic                          r4_clip, r4_neg;
    logic [SB-1:0]                 r4_byp;
    assign n_cp = r3_sq * r3_m;
    always_comb begin
        n_zneg = r3_neg;
        unique case (mode)
            wsd_pkg::MODE_HARD: n_num = wsd_pkg::NUM_BITS'(r3_sq)
                                        + wsd_pkg::NUM_BITS'(r3_m);
            wsd_pkg::MODE_HF1, wsd_pkg::MODE_HF2: begin
                if (wsd_pkg::SQ_BITS'(r3_m) >= r3_sq) begin
                    n_num = wsd_pkg::NUM_BITS'(wsd_pkg::SQ_BITS'(r3_m) - r3_sq);
                end else begin
                    n_num  = wsd_pkg::NUM_BITS'(r3_sq - wsd_pkg::SQ_BITS'(r3_m));
                    n_zneg = !r3_neg;
                end
            end
            default: n_num = wsd_pkg::NUM_BITS'(r3_m);
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_cube <= n_cp[wsd_pkg::IFRAC +: wsd_pkg::CUBE_BITS];
            r4_sq   <= r3_sq;
            r4_m    <= r3_m;
            r4_num  <= n_num;
            r4_clip <= r3_clip;
            r4_neg  <= n_zneg;
            r4_byp  <= r3_byp;
        end
    end

    // Stage 5: denominator and clamp value; divider pipeline follows.
    logic [wsd_pkg::CUBE_BITS-1:0] n_den;
    logic [wsd_pkg::REM_BITS-1:0]  r_rem [0:DB];
    logic [wsd_pkg::CUBE_BITS-1:0] r_den [0:DB];
    logic [DB-1:0]                 r_q   [0:DB];
    logic [DB-1:0]                 r_dig [0:DB];
    logic                          r_clp [0:DB];
    logic                          r_sgn [0:DB];
    logic [SB-1:0]                 r_bq  [0:DB];
    always_comb begin
        unique case (mode)
            wsd_pkg::MODE_SOFT: n_den = wsd_pkg::CUBE_BITS'(r4_m) + wsd_pkg::K07;
            wsd_pkg::MODE_HARD: n_den = wsd_pkg::CUBE_BITS'(r4_sq) + wsd_pkg::ONE_Q;
            wsd_pkg::MODE_HF0:  n_den = wsd_pkg::CUBE_BITS'(r4_sq) + wsd_pkg::K07;
            wsd_pkg::MODE_HF2:  n_den = r4_cube + wsd_pkg::K06;
            default:            n_den = wsd_pkg::CUBE_BITS'(r4_sq) + wsd_pkg::K06;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= wsd_pkg::REM_BITS'(r4_num) << wsd_pkg::IFRAC;
            r_den[0] <= n_den;
            r_q[0]   <= '0;
            r_dig[0] <= (r4_m > wsd_pkg::HALF_Q) ? DB'(wsd_pkg::HALF_Q) << 1
                                                 : DB'(r4_m) << 1;
            r_clp[0] <= r4_clip;
            r_sgn[0] <= r4_neg;
            r_bq[0]  <= r4_byp;
        end
    end

    for (genvar k = 0; k < DB; k++) begin : g_div
        logic [wsd_pkg::REM_BITS-1:0] n_dsh;
        logic                         n_ge;
        assign n_dsh = wsd_pkg::REM_BITS'(r_den[k]) << (DB - 1 - k);
        assign n_ge  = r_rem[k] >= n_dsh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_ge ? r_rem[k] - n_dsh : r_rem[k];
                r_q[k+1]   <= r_q[k] | (n_ge ? DB'(1) << (DB - 1 - k) : DB'(0));
                r_den[k+1] <= r_den[k];
                r_dig[k+1] <= r_dig[k];
                r_clp[k+1] <= r_clp[k];
                r_sgn[k+1] <= r_sgn[k];
                r_bq[k+1]  <= r_bq[k];
            end
        end
    end

    // Scale by 0.3.
    logic [PW-1:0]  r6_prod;
    logic           r6_clip, r6_neg;
    logic [SB-1:0]  r6_byp;
    logic [DB-1:0]  n_zm;
    assign n_zm = (mode == wsd_pkg::MODE_DIGITAL) ? r_dig[DB] : r_q[DB];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_prod <= n_zm * wsd_pkg::K03;
            r6_clip <= r_clp[DB];
            r6_neg  <= r_sgn[DB];
            r6_byp  <= r_bq[DB];
        end
    end

    // Saturate and restore sign.
    logic [PW-1:0] n_qv, n_lim;
    logic [SB-1:0] n_qs;
    logic          n_sat;
    always_comb begin
        n_qv  = byp ? PW'(r6_byp) : (r6_prod >> OUT_SHIFT);
        n_lim = (PW'(1) << (SB - 1)) - PW'(!r6_neg);
        n_sat = n_qv > n_lim;
        n_qs  = n_sat ? n_lim[SB-1:0] : n_qv[SB-1:0];
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_out  <= r6_neg ? (~n_qs + SB'(1)) : n_qs;
            o_clip <= r6_clip | n_sat;
        end
    end
endmodule
`default_nettype wire

// ----- design/stereo_waveshaper_distortion.sv -----
// Top level of the stereo waveshaper: APB register file, valid pipeline and two channels.
// Depends on wsd_pkg and wsd_channel.
//
// Usage: a stereo pair enters on i_valid/o_ready and one shaped word leaves on
// o_valid/i_ready, carrying both channels and the clipped flag.
// From acceptance to o_valid a word passes the 22-stage restoring divider plus seven
// multiply, clamp and scaling stages.
// Throughput is one word per cycle unless the receiver stalls; the whole pipeline advances in lockstep.
// When the receiver stalls with a finished word waiting, the whole pipeline freezes,
// bubbles included, and o_ready falls until the word is taken.
// Reset clears all valid bits and loads shape_mode 1 and drive_gain 3072.
// Registers are written over APB at byte address 0 (mode) and 4 (gain), by the user only while idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none
module stereo_waveshaper_distortion #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 20
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [SAMPLE_BITS-1:0] i_left_sample,
    input  wire logic [SAMPLE_BITS-1:0] i_right_sample,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic      [SAMPLE_BITS-1:0] o_left_out,
    output logic      [SAMPLE_BITS-1:0] o_right_out,
    output logic                        o_clipped,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic      [31:0]            prdata,
    output logic                        pready
);
    localparam int L = wsd_pkg::LATENCY;

    logic [2:0]  r_mode;
    logic [15:0] r_gain;
    logic [L-1:0] r_v;
    logic        en, wr, clip_l, clip_r;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == wsd_pkg::ADDR_GAIN) ? {16'd0, r_gain} : {29'd0, r_mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= wsd_pkg::MODE_SOFT;
            r_gain <= 16'd3072;
        end else if (wr) begin
            if (paddr[2] == wsd_pkg::ADDR_MODE) begin
                r_mode <= pwdata[2:0];
            end else begin
                r_gain <= pwdata[15:0];
            end
        end
    end

    assign en      = !r_v[L-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[L-2:0], i_valid};
        end
    end

    wsd_channel #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_left (
        .i_clk(i_clk), .i_en(en), .i_sample(i_left_sample), .i_mode(r_mode),
        .i_gain(r_gain), .o_out(o_left_out), .o_clip(clip_l)
    );
    wsd_channel #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_right (
        .i_clk(i_clk), .i_en(en), .i_sample(i_right_sample), .i_mode(r_mode),
        .i_gain(r_gain), .o_out(o_right_out), .o_clip(clip_r)
    );
    assign o_clipped = clip_l | clip_r;

`ifndef SYNTHESIS
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready) else $error("stalled word not held");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_left_out)
        && $stable(o_right_out))) else $error("word changed during stall");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v[0]) else $error("accepted word lost");
    a_mode_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && paddr[2] == wsd_pkg::ADDR_MODE) |=> r_mode == $past(pwdata[2:0]))
        else $error("mode write failed");
`endif
endmodule
`default_nettype wire
